@@ sv/platoon_follow_overtake_steering_assert.svh @@
// Assertion macros used by the checker file of the steering block.
// Depends on nothing.
`ifndef PLATOON_FOLLOW_OVERTAKE_STEERING_ASSERT_SVH
`define PLATOON_FOLLOW_OVERTAKE_STEERING_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PFOS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication.
`define PFOS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ sv/pfos_pkg.sv @@
// Steering package: payload structs, constants, arctangent table and a 16-bit clamp.
// Depends on nothing.
package pfos_pkg;
    typedef struct packed {
        logic signed [15:0] leader_x;
        logic signed [15:0] leader_y;
        logic signed [15:0] follower_x;
        logic signed [15:0] follower_y;
        logic signed [15:0] leader_heading;
        logic signed [15:0] follower_heading;
        logic signed [15:0] leader_vel_x;
        logic signed [15:0] leader_vel_y;
        logic signed [15:0] leader_vel_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] speed_cmd;
        logic signed [15:0] steer_cmd;
        logic [1:0]         phase_now;
    } t_out;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic [1:0] REG_OVERTAKE_MODE = 2'd0;

    localparam logic signed [47:0] C_005 = 48'sd13;
    localparam logic signed [47:0] C_01  = 48'sd26;
    localparam logic signed [47:0] C_025 = 48'sd64;

    function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0: v = 32'sd843314856;  5'd1: v = 32'sd497837829;
            5'd2: v = 32'sd263043836;  5'd3: v = 32'sd133525158;
            5'd4: v = 32'sd67021686;   5'd5: v = 32'sd33543515;
            5'd6: v = 32'sd16775850;   5'd7: v = 32'sd8388437;
            5'd8: v = 32'sd4194282;    5'd9: v = 32'sd2097149;
            5'd10: v = 32'sd1048575;   5'd11: v = 32'sd524287;
            5'd12: v = 32'sd262143;    5'd13: v = 32'sd131071;
            5'd14: v = 32'sd65535;     5'd15: v = 32'sd32767;
            5'd16: v = 32'sd16383;     5'd17: v = 32'sd8191;
            5'd18: v = 32'sd4095;      5'd19: v = 32'sd2047;
            5'd20: v = 32'sd1023;      5'd21: v = 32'sd511;
            5'd22: v = 32'sd255;       5'd23: v = 32'sd127;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767) r = 16'sh7fff;
        else if (v < -48'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction
endpackage

@@ sv/platoon_follow_overtake_steering.sv @@
// Top level of the platoon steering block: register port, sequencer and output register.
// Depends on pfos_pkg, pfos_isqrt and pfos_cordic.
//
//  channel | direction | handshake          | payload
//  in      | request   | i_in_valid/o_in_stall  | pfos_pkg::t_in
//  out     | result    | o_out_valid/i_out_stall | pfos_pkg::t_out
//  cfg     | APB write | psel/penable/pwrite     | overtake_mode
//
// Once a request is taken, the square root and the CORDIC run side by side;
// their done flags are then registered, and once both are set the result is
// formed and written to the output register.
// Reset is synchronous; the phase returns to the first phase and mode to follow.
// The output register holds a result while stalled; the next request is taken
// only once the previous result has been delivered.
module platoon_follow_overtake_steering #(
    parameter int ANGLE_FRAC_BITS = 12,
    parameter int CORDIC_STEPS    = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pfos_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pfos_pkg::t_out       o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  r_state;
    logic        r_mode, r_sq_ok, r_cd_ok;
    logic        r_far;
    logic [1:0]  r_phase;
    pfos_pkg::t_in  r_in;
    pfos_pkg::t_out r_out;
    logic signed [16:0] w_dx, w_dy;
    logic signed [16:0] w_alpha;
    logic [35:0] w_rad;
    logic signed [19:0] w_cy, w_cx, w_e;
    logic        w_acc, w_sq_done, w_cd_done;
    logic [17:0] w_root;
    logic signed [47:0] w_ang, w_speed, w_steer, w_abs;
    logic [1:0]  w_next;
    logic [47:0] w_s;
    logic [19:0] w_q;
    logic [39:0] w_prod;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_mode};
    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc = i_in_valid && !o_in_stall;

    assign w_dx = 17'(i_in_data.leader_x) - 17'(i_in_data.follower_x);
    assign w_dy = 17'(i_in_data.leader_y) - 17'(i_in_data.follower_y);
    assign w_e = (r_phase == pfos_pkg::PH_FIRST) ? 20'sd4 * (20'sd64 - 20'(w_dx))
               : (r_phase == pfos_pkg::PH_SECOND) ? 20'sd3 * (20'sd64 - 20'(w_dx))
               : -20'sd3 * 20'(w_dx);

    always_comb begin
        if (!r_mode) begin
            w_rad = 36'(34'(w_dx * w_dx) + 34'(w_dy * w_dy));
            w_cy = 20'(w_dy); w_cx = 20'(w_dx);
        end else begin
            w_rad = 36'(i_in_data.leader_vel_x * i_in_data.leader_vel_x)
                  + 36'(i_in_data.leader_vel_y * i_in_data.leader_vel_y)
                  + 36'(i_in_data.leader_vel_z * i_in_data.leader_vel_z);
            w_cy = w_e; w_cx = 20'sd256;
        end
    end

    pfos_isqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_acc), .i_rad(w_rad),
        .o_done(w_sq_done), .o_root(w_root)
    );
    pfos_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_acc), .i_y(w_cy), .i_x(w_cx),
        .o_done(w_cd_done), .o_angle(w_ang)
    );

    // Finishing arithmetic works from the captured request.
    always_comb begin
        w_alpha = 17'(r_in.leader_heading) - 17'(r_in.follower_heading);
        w_abs = (w_alpha < 0) ? -48'(w_alpha) : 48'(w_alpha);
        w_s = 48'(r_in.leader_y) - 48'(r_in.follower_y);
        // Dividing by ten through a reciprocal multiply is exact for any 20-bit numerator.
        w_q = 20'd3 * {2'b00, w_root} + 20'd5;
        w_prod = 40'(w_q) * 40'd838861;
        w_next = r_phase;
        if (!r_mode) begin
            w_speed = r_far ? 48'(w_prod[39:23]) : pfos_pkg::C_005;
            w_steer = (w_ang - 48'(r_in.follower_heading)) >>> 1;
        end else begin
            w_steer = w_ang + 48'(w_alpha);
            if (r_phase == pfos_pkg::PH_FIRST) begin
                w_speed = 48'(w_root) - pfos_pkg::C_005;
                if (48'sd20 * w_abs < (48'sd1 <<< ANGLE_FRAC_BITS)) w_next = pfos_pkg::PH_SECOND;
            end else if (r_phase == pfos_pkg::PH_SECOND) begin
                w_speed = 48'(w_root) + pfos_pkg::C_01;
                if (48'sd5 * $signed(w_s) < -48'sd512) w_next = pfos_pkg::PH_THIRD;
            end else begin
                w_speed = 48'(w_root);
                w_next = pfos_pkg::PH_THIRD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // A distance above 0.4 m is a squared distance above 10485 in Q7.8 units.
        if (w_acc) begin
            r_in <= i_in_data;
            r_far <= (w_rad > 36'd10485);
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_mode <= 1'b0; r_phase <= pfos_pkg::PH_FIRST;
            r_sq_ok <= 1'b0; r_cd_ok <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == pfos_pkg::REG_OVERTAKE_MODE)
                r_mode <= pwdata[0];
            case (r_state)
                S_IDLE: if (w_acc) begin
                    r_state <= S_RUN; r_sq_ok <= 1'b0; r_cd_ok <= 1'b0;
                end
                S_RUN: begin
                    if (w_sq_done) r_sq_ok <= 1'b1;
                    if (w_cd_done) r_cd_ok <= 1'b1;
                    if (r_sq_ok && r_cd_ok) begin
                        r_out.speed_cmd <= pfos_pkg::sat16(w_speed);
                        r_out.steer_cmd <= pfos_pkg::sat16(w_steer);
                        r_out.phase_now <= w_next;
                        r_phase <= w_next;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (!i_out_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data = r_out;
endmodule

@@ sv/pfos_isqrt.sv @@
// Digit-serial integer square root, one result bit (two radicand bits) per cycle.
// Depends on nothing.
module pfos_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [35:0] i_rad,
    output logic        o_done,
    output logic [17:0] o_root
);
    logic [35:0] r_rad, n_rad;
    logic [19:0] r_rem, n_rem;
    logic [17:0] r_root, n_root;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [19:0] w_rem, w_trial;

    always_comb begin
        n_rad = r_rad; n_rem = r_rem; n_root = r_root;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_rem = {r_rem[17:0], r_rad[35:34]};
        w_trial = {r_root, 2'b01};
        if (i_start) begin
            n_rad = i_rad; n_rem = '0; n_root = '0;
            n_cnt = 5'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[33:0], 2'b00};
            if (w_rem >= w_trial) begin
                n_rem = w_rem - w_trial;
                n_root = {r_root[16:0], 1'b1};
            end else begin
                n_rem = w_rem;
                n_root = {r_root[16:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd17) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad <= n_rad; r_rem <= n_rem; r_root <= n_root; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ sv/pfos_cordic.sv @@
// Iterative CORDIC vectoring unit for atan2, one micro-rotation per cycle.
// Depends on pfos_pkg.
module pfos_cordic #(
    parameter int ANGLE_FRAC_BITS = 12,
    parameter int CORDIC_STEPS    = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [19:0]  i_y,
    input  logic signed [19:0]  i_x,
    output logic                o_done,
    output logic signed [47:0]  o_angle
);
    localparam int STEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int RSH   = 30 - ANGLE_FRAC_BITS;

    logic signed [31:0] r_x, n_x, r_y, n_y;
    logic signed [33:0] r_z, n_z;
    logic [4:0]         r_i, n_i;
    logic               r_busy, n_busy, r_done, n_done, r_zero, n_zero;
    logic signed [31:0] w_xs, w_ys, w_x0, w_y0;
    logic signed [33:0] w_zr;

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i;
        n_busy = r_busy; n_done = 1'b0; n_zero = r_zero;
        w_x0 = 32'(i_x) <<< 8;
        w_y0 = 32'(i_y) <<< 8;
        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
        if (i_start) begin
            n_i = '0;
            n_zero = (i_x == 20'sd0) && (i_y == 20'sd0);
            n_busy = 1'b1;
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    n_x = w_y0; n_y = -w_x0; n_z = 34'(pfos_pkg::atan_entry(5'd0)) <<< 1;
                end else begin
                    n_x = -w_y0; n_y = w_x0; n_z = -(34'(pfos_pkg::atan_entry(5'd0)) <<< 1);
                end
            end else begin
                n_x = w_x0; n_y = w_y0; n_z = '0;
            end
        end else if (r_busy) begin
            if (r_y < 0) begin
                n_x = r_x - w_ys; n_y = r_y + w_xs;
                n_z = r_z - 34'(pfos_pkg::atan_entry(r_i));
            end else begin
                n_x = r_x + w_ys; n_y = r_y - w_xs;
                n_z = r_z + 34'(pfos_pkg::atan_entry(r_i));
            end
            n_i = r_i + 5'd1;
            if (r_i == 5'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_i <= n_i; r_zero <= n_zero;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign w_zr = (r_z + (34'sd1 <<< (RSH - 1))) >>> RSH;
    assign o_angle = r_zero ? 48'sd0 : 48'(w_zr);
    assign o_done = r_done;
endmodule

@@ sv/pfos_checker.sv @@
// Port-level checker for the steering block, bound to the top level.
// Depends on pfos_pkg and the assertion macro header.
`include "platoon_follow_overtake_steering_assert.svh"
module pfos_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input pfos_pkg::t_out o_out_data
);
    logic w_phase_ok, w_held, w_taken;

    assign w_phase_ok = (o_out_data.phase_now <= pfos_pkg::PH_THIRD);
    assign w_held     = o_out_valid && i_out_stall;
    assign w_taken    = i_in_valid && !o_in_stall;

    `PFOS_ASSERT_IMP(a_phase_legal, i_clk, i_rst_n, o_out_valid, w_phase_ok)
    `PFOS_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `PFOS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_held, o_out_valid && $stable(o_out_data))
    `PFOS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_taken, o_in_stall && !o_out_valid)
endmodule

bind platoon_follow_overtake_steering pfos_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
);

@@ test/platoon_follow_overtake_steering_tb.sv @@
// Testbench of the platoon steering block: follow control and overtake phases.
// Depends on pfos_pkg and platoon_follow_overtake_steering; predicts each result itself.
`timescale 1ns / 1ps
module platoon_follow_overtake_steering_tb;
    localparam int ANGLE_FB = 12;
    localparam int ROT_STEPS = 14;
    localparam int CYCLE_LIMIT = 1500000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_stall;
    pfos_pkg::t_in  i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    pfos_pkg::t_out o_out_data;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [1:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    platoon_follow_overtake_steering dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state and the queue of commands still to arrive.
    logic           mode_q;
    logic [1:0]     phase_q;
    pfos_pkg::t_out pending_cmds[$];
    int             mismatches = 0;
    int             cycles = 0;
    int             sent = 0;
    int             got = 0;
    int             phase_hits[3];
    bit             idle_on = 1'b1;
    int             stall_left = 0;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint s);
        longint r = 0;
        longint b = 64'sd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint z = 0;
        longint t, xs, ys;
        if (x == 0 && y == 0) return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; z = 2 * longint'(pfos_pkg::atan_entry(5'd0));
            end else begin
                t = -y; y = x; x = t; z = -2 * longint'(pfos_pkg::atan_entry(5'd0));
            end
        end
        for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y < 0) begin
                x -= ys; y += xs; z -= longint'(pfos_pkg::atan_entry(i[4:0]));
            end else begin
                x += ys; y -= xs; z += longint'(pfos_pkg::atan_entry(i[4:0]));
            end
        end
        return shr_floor(z + (64'sd1 << (29 - ANGLE_FB)), 30 - ANGLE_FB);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic pfos_pkg::t_out steering_for(pfos_pkg::t_in d);
        pfos_pkg::t_out o;
        longint dx, dy, s, r, spd, str, al, aa, vm, e, k;
        logic [1:0] nxt;
        dx = longint'(d.leader_x) - longint'(d.follower_x);
        dy = longint'(d.leader_y) - longint'(d.follower_y);
        if (!mode_q) begin
            s = dx * dx + dy * dy;
            r = root_floor(s);
            spd = (25 * s > 262144) ? (3 * r + 5) / 10 : 13;
            str = shr_floor(angle_of(dy, dx) - longint'(d.follower_heading), 1);
        end else begin
            al = longint'(d.leader_heading) - longint'(d.follower_heading);
            aa = al < 0 ? -al : al;
            vm = root_floor(longint'(d.leader_vel_x) * d.leader_vel_x
                 + longint'(d.leader_vel_y) * d.leader_vel_y
                 + longint'(d.leader_vel_z) * d.leader_vel_z);
            nxt = phase_q;
            if (phase_q == pfos_pkg::PH_FIRST) begin
                e = 64 - dx; k = 4; spd = vm - 13;
                if (20 * aa < (64'sd1 << ANGLE_FB)) nxt = pfos_pkg::PH_SECOND;
            end else if (phase_q == pfos_pkg::PH_SECOND) begin
                e = 64 - dx; k = 3; spd = vm + 26;
                if (5 * dy < -512) nxt = pfos_pkg::PH_THIRD;
            end else begin
                e = -dx; k = 3; spd = vm; nxt = pfos_pkg::PH_THIRD;
            end
            str = angle_of(k * e, 256) + al;
            phase_q = nxt;
        end
        o.speed_cmd = clip16(spd);
        o.steer_cmd = clip16(str);
        o.phase_now = phase_q;
        return o;
    endfunction

    task automatic send_request(pfos_pkg::t_in d);
        int gap;
        if (idle_on && $urandom_range(3) == 0) begin
            gap = $urandom_range(8, 1);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_cmds.push_back(steering_for(d));
        phase_hits[phase_q]++;
        sent++;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [31:0] v);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= pfos_pkg::REG_OVERTAKE_MODE << 2;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mode_q = v[0];
        @(posedge i_clk);
    endtask

    // Random stall bursts on the result side, while idle_on is set.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(5) == 0) begin
            stall_left <= $urandom_range(8, 1);
            i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        pfos_pkg::t_out want;
        cycles++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got++;
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                want = pending_cmds.pop_front();
                if (want.speed_cmd !== o_out_data.speed_cmd
                    || want.steer_cmd !== o_out_data.steer_cmd
                    || want.phase_now !== o_out_data.phase_now) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_out_data);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** platoon_follow_overtake_steering: FAILED **");
            $finish;
        end
    end

    function automatic pfos_pkg::t_in random_request(bit near);
        pfos_pkg::t_in d;
        d = pfos_pkg::t_in'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        if (near) begin
            d.leader_x = $signed(16'($urandom_range(1024))) - 16'sd512;
            d.follower_x = $signed(16'($urandom_range(1024))) - 16'sd512;
            d.leader_y = $signed(16'($urandom_range(1024))) - 16'sd512;
            d.follower_y = $signed(16'($urandom_range(1024))) - 16'sd512;
            d.leader_heading = $signed(16'($urandom_range(1600))) - 16'sd800;
            d.follower_heading = d.leader_heading
                                 + $signed(16'($urandom_range(600))) - 16'sd300;
            d.leader_vel_x = $signed(16'($urandom_range(2048))) - 16'sd1024;
            d.leader_vel_y = $signed(16'($urandom_range(2048))) - 16'sd1024;
            d.leader_vel_z = $signed(16'($urandom_range(64))) - 16'sd32;
        end
        return d;
    endfunction

    task automatic test_directed_follow();
        pfos_pkg::t_in d;
        write_mode(32'd0);
        d = '0; send_request(d);
        d = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_request(d);
        d = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh8000, 16'sh8000, 16'sh8000};
        send_request(d);
        // Distance just at and just past the 0.4 m threshold.
        d = '0; d.leader_x = 16'sd102; send_request(d);
        d.leader_x = 16'sd103; send_request(d);
        d = '0; d.leader_x = -16'sd200; d.leader_y = 16'sd1; send_request(d);
        d.leader_y = -16'sd1; send_request(d);
        d = '0; d.leader_y = 16'sd300; send_request(d);
    endtask

    task automatic test_directed_overtake();
        pfos_pkg::t_in d;
        // Only bit 0 of the register counts.
        write_mode(32'hffff_fffe);
        write_mode(32'd1);
        d = '0; d.leader_heading = 16'sd300; send_request(d);
        d.leader_heading = 16'sd204; send_request(d);
        d.leader_heading = 16'sd205; send_request(d);
        d = '0; d.leader_y = -16'sd102; send_request(d);
        d.leader_y = -16'sd103; send_request(d);
        d = '0; d.leader_x = 16'sh7fff; d.follower_x = 16'sh8000;
        d.leader_vel_x = 16'sh8000; d.leader_vel_y = 16'sh8000;
        d.leader_vel_z = 16'sh8000; send_request(d);
        d.leader_x = 16'sh8000; d.follower_x = 16'sh7fff;
        d.leader_heading = 16'sh7fff; d.follower_heading = 16'sh8000; send_request(d);
        // Follow mode keeps the phase, then overtake carries on in it.
        write_mode(32'd0);
        d = random_request(1'b0); send_request(d);
        write_mode(32'd1);
        send_request(d);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                write_mode({31'd0, 1'($urandom)});
                // Restarting the overtake sequence needs a reset, so runs stay in phase.
            end
            if (i == n / 2) begin
                drain();
            end
            if (i > n - n / 8) idle_on = 1'b0;
            send_request(random_request($urandom_range(3) != 0));
        end
    endtask

    initial begin
        mode_q = 1'b0;
        phase_q = pfos_pkg::PH_FIRST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_follow();
        test_directed_overtake();
        test_random(1800);
        drain();
        $display("sent %0d requests, checked %0d results; phases seen %0d/%0d/%0d",
                 sent, got, phase_hits[0], phase_hits[1], phase_hits[2]);
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("** platoon_follow_overtake_steering: PASSED **");
        end else begin
            $display("** platoon_follow_overtake_steering: FAILED **");
        end
        $finish;
    end
endmodule
